// ===== hw/rtl/dncd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dncd_pkg;

	localparam int DAY_W   = 22;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DOM_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int YINC_W  = 13;
	localparam int QINC_W  = 5;
	localparam int STEP_W  = 4;

	// period lengths in days
	localparam int D1   = 365;
	localparam int D4   = D1 * 4 + 1;
	localparam int D100 = D4 * 25 - 1;
	localparam int D400 = D100 * 4 + 1;

	localparam logic [STEP_W-1:0] STEP_WALK = STEP_W'(14);
	localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(15);
	localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(11);

	typedef enum logic [1:0] {
		OP_SUB,
		OP_WALK,
		OP_DONE
	} op_t;

	typedef enum logic [1:0] {
		Q_NONE,
		Q_CENT,
		Q_QUAD,
		Q_YEAR
	} qsel_t;

	typedef struct packed {
		op_t               op;
		logic [DAY_W-1:0]  kval;
		logic [YINC_W-1:0] yinc;
		qsel_t             qsel;
		logic [QINC_W-1:0] qinc;
		logic [STEP_W-1:0] jmp;
	} ctl_t;

	function automatic ctl_t mk_sub(input int k, input int yi, input qsel_t qs, input int qi);
		ctl_t c;
		c.op   = OP_SUB;
		c.kval = DAY_W'(k);
		c.yinc = YINC_W'(yi);
		c.qsel = qs;
		c.qinc = QINC_W'(qi);
		c.jmp  = '0;
		return c;
	endfunction

	// microprogram: binary-weighted conditional subtracts, then the month walk
	function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
		ctl_t c;
		c = '{op: OP_DONE, kval: '0, yinc: '0, qsel: Q_NONE, qinc: '0, jmp: '0};
		case (step)
			4'd0:  c = mk_sub(D400 * 16, 6400, Q_NONE, 0);
			4'd1:  c = mk_sub(D400 * 8, 3200, Q_NONE, 0);
			4'd2:  c = mk_sub(D400 * 4, 1600, Q_NONE, 0);
			4'd3:  c = mk_sub(D400 * 2, 800, Q_NONE, 0);
			4'd4:  c = mk_sub(D400, 400, Q_NONE, 0);
			4'd5:  c = mk_sub(D100 * 2, 200, Q_CENT, 2);
			4'd6:  c = mk_sub(D100, 100, Q_CENT, 1);
			4'd7:  c = mk_sub(D4 * 16, 64, Q_QUAD, 16);
			4'd8:  c = mk_sub(D4 * 8, 32, Q_QUAD, 8);
			4'd9:  c = mk_sub(D4 * 4, 16, Q_QUAD, 4);
			4'd10: c = mk_sub(D4 * 2, 8, Q_QUAD, 2);
			4'd11: c = mk_sub(D4, 4, Q_QUAD, 1);
			4'd12: c = mk_sub(D1 * 2, 2, Q_YEAR, 2);
			4'd13: c = mk_sub(D1, 1, Q_YEAR, 1);
			4'd14: begin
				c.op  = OP_WALK;
				c.jmp = STEP_WALK;
			end
			default: c.op = OP_DONE;
		endcase
		return c;
	endfunction

	function automatic logic [DOM_W-1:0] month_len(input logic leap,
		input logic [MONTH_W-1:0] m);
		logic [DOM_W-1:0] n;
		case (m)
			4'd1:                      n = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
			default:                   n = 5'd31;
		endcase
		return n;
	endfunction

	typedef struct packed {
		logic walk_more;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dncd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dncd_in_if import dncd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DAY_W-1:0] day_count;

	modport source (output valid, output day_count, input ready);
	modport sink (input valid, input day_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dncd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dncd_out_if import dncd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DOM_W-1:0]   day_of_month;
	logic [WDAY_W-1:0]  weekday;
	logic               leap_year;
	logic               valid_res;

	modport source (output valid, output year, output month, output day_of_month,
		output weekday, output leap_year, output valid_res, input ready);
	modport sink (input valid, input year, input month, input day_of_month,
		input weekday, input leap_year, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dncd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dncd_dp import dncd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic [DAY_W-1:0]   day_count,
	input  wire logic               run,
	input  wire ctl_t               ctl,
	output dp_stat_t                stat,
	output logic [YEAR_W-1:0]       year,
	output logic [MONTH_W-1:0]      month,
	output logic [DOM_W-1:0]        day_of_month,
	output logic [WDAY_W-1:0]       weekday,
	output logic                    leap_year,
	output logic                    valid_res
);

	logic [DAY_W-1:0]   r_q;
	logic [YEAR_W-1:0]  year_q;
	logic [1:0]         cent_q;
	logic [4:0]         quad_q;
	logic [1:0]         yr_q;
	logic [MONTH_W-1:0] m_q;
	logic [WDAY_W-1:0]  wd_q;
	logic               ok_q;

	logic               leap;
	logic               ge;
	logic [DOM_W-1:0]   mlen;
	logic               take;
	logic [5:0]         dsum;
	logic [3:0]         fold1;
	logic [3:0]         fold2;
	logic [2:0]         mod7;
	logic [23:0]        dc_ext;

	// count mod 7: octal digits fold since 8 = 1 mod 7
	always_comb begin
		dc_ext = {2'b00, day_count};
		dsum   = '0;
		for (int i = 0; i < 8; i++) begin
			dsum = dsum + 6'(dc_ext[3*i +: 3]);
		end
		fold1 = 4'(dsum[5:3]) + 4'(dsum[2:0]);
		fold2 = 4'(fold1[3]) + 4'(fold1[2:0]);
		mod7  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
	end

	// year = 1 + 400a + 100b + 4c + e; divisible by 4 iff e == 3
	assign leap = (yr_q == 2'd3) && ((quad_q != 5'd24) || (cent_q == 2'd3));
	assign ge   = r_q >= ctl.kval;
	assign mlen = month_len(leap, m_q);
	assign take = (m_q < MONTH_LAST) && (r_q >= DAY_W'(mlen));
	assign stat.walk_more = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (load) begin
			ok_q <= day_count != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r_q    <= day_count - DAY_W'(1);
			year_q <= YEAR_W'(1);
			cent_q <= '0;
			quad_q <= '0;
			yr_q   <= '0;
			m_q    <= '0;
			wd_q   <= mod7 + 3'd1;
		end else if (run) begin
			case (ctl.op)
				OP_SUB: begin
					if (ge) begin
						r_q    <= r_q - ctl.kval;
						year_q <= year_q + YEAR_W'(ctl.yinc);
						case (ctl.qsel)
							Q_CENT:  cent_q <= cent_q + ctl.qinc[1:0];
							Q_QUAD:  quad_q <= quad_q + ctl.qinc;
							Q_YEAR:  yr_q <= yr_q + ctl.qinc[1:0];
							default: ;
						endcase
					end
				end
				OP_WALK: begin
					if (take) begin
						r_q <= r_q - DAY_W'(mlen);
						m_q <= m_q + MONTH_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// zero count reports all zeros
	assign year         = ok_q ? year_q : '0;
	assign month        = ok_q ? m_q + MONTH_W'(1) : '0;
	assign day_of_month = ok_q ? r_q[DOM_W-1:0] + DOM_W'(1) : '0;
	assign weekday      = ok_q ? wd_q : '0;
	assign leap_year    = ok_q & leap;
	assign valid_res    = ok_q;

endmodule

`default_nettype wire

// ===== hw/rtl/day_number_to_calendar_date.sv =====
// Day number to calendar date decoder (proleptic Gregorian).
//
// Channels: din carries one item, a 22-bit day_count with 1 = 0001-01-01.
// dout carries year, month, day_of_month, weekday (1 = Sunday), leap_year
// and valid_res. A count of zero gives an all-zero result with valid_res low.
//
// A microprogram in a small constant table steps a subtract-and-compare datapath:
// 14 steps split the count into 400/100/4/1-year periods with binary
// weighted conditional subtracts, then one step repeats to walk the months
// (once per month passed), then a done step moves the result to the output
// register. The next item is taken the cycle after the done step, as din.ready
// is low while busy, so a new item is not accepted before the last is done.
//
// Reset clears the sequencer and the output valid. When dout stalls, the
// finished result holds in the output register; the sequencer waits in its
// done step only if a second result is ready before the first is taken.
`timescale 1ns / 1ps
`default_nettype none

module day_number_to_calendar_date import dncd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	dncd_in_if.sink   din,
	dncd_out_if.source dout
);

	logic [STEP_W-1:0]  sc_q;
	logic               busy_q;
	logic               out_vld_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DOM_W-1:0]   dom_q;
	logic [WDAY_W-1:0]  wday_q;
	logic               leap_q;
	logic               vres_q;

	ctl_t               ctl;
	dp_stat_t           stat;
	logic               load;
	logic               done_fire;
	logic [YEAR_W-1:0]  dp_year;
	logic [MONTH_W-1:0] dp_month;
	logic [DOM_W-1:0]   dp_dom;
	logic [WDAY_W-1:0]  dp_wday;
	logic               dp_leap;
	logic               dp_vres;

	// fetch the control word for the current step
	assign ctl       = ucode(sc_q);
	assign din.ready = !busy_q;
	assign load      = din.valid && din.ready;
	assign done_fire = busy_q && (ctl.op == OP_DONE) && (!out_vld_q || dout.ready);

	dncd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.day_count    (din.day_count),
		.run          (busy_q),
		.ctl          (ctl),
		.stat         (stat),
		.year         (dp_year),
		.month        (dp_month),
		.day_of_month (dp_dom),
		.weekday      (dp_wday),
		.leap_year    (dp_leap),
		.valid_res    (dp_vres)
	);

	// step counter: advance, loop on the walk step, hold at done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q   <= '0;
			busy_q <= 1'b0;
		end else if (load) begin
			sc_q   <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			case (ctl.op)
				OP_SUB:  sc_q <= sc_q + STEP_W'(1);
				OP_WALK: sc_q <= stat.walk_more ? ctl.jmp : sc_q + STEP_W'(1);
				default: begin
					if (done_fire) begin
						busy_q <= 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done_fire) begin
			out_vld_q <= 1'b1;
		end else if (dout.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			year_q  <= dp_year;
			month_q <= dp_month;
			dom_q   <= dp_dom;
			wday_q  <= dp_wday;
			leap_q  <= dp_leap;
			vres_q  <= dp_vres;
		end
	end

	assign dout.valid        = out_vld_q;
	assign dout.year         = year_q;
	assign dout.month        = month_q;
	assign dout.day_of_month = dom_q;
	assign dout.weekday      = wday_q;
	assign dout.leap_year    = leap_q;
	assign dout.valid_res    = vres_q;

`ifndef ASSERT_OFF
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && sc_q == '0))
		else $error("accepted item did not start the microprogram");

	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && sc_q == STEP_WALK && !stat.walk_more) |=> (sc_q == STEP_DONE))
		else $error("month walk did not advance to done");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.valid_res) |->
		(dout.year == '0 && dout.month == '0 && dout.day_of_month == '0
		&& dout.weekday == '0 && !dout.leap_year))
		else $error("invalid result carries nonzero fields");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.valid_res) |->
		(dout.month != '0 && dout.month <= MONTH_W'(12) && dout.day_of_month != '0
		&& dout.weekday != '0))
		else $error("decoded date out of range");
`endif

endmodule

`default_nettype wire
